### rtl/kfcl_pkg.sv
package kfcl_pkg;

    // Keyframe storage
    localparam int MAX_KEYS  = 16;
    localparam int KEY_LIMIT = (MAX_KEYS < 16) ? MAX_KEYS : 16;
    localparam int KEY_AW    = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;
    localparam int CNT_W     = 5;

    // Interpolation lanes: five primitive bytes (lod lowest) then four environment bytes
    localparam int PRIM_LANES = 5;
    localparam int NUM_LANES  = 9;
    localparam int WORD_W     = 8 * NUM_LANES;

    // Divider: |delta| (8 bits) times |offset| (16 bits)
    localparam int PROD_W = 24;
    localparam int STEP_W = $clog2(PROD_W);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        REG_LOOP_LENGTH = 2'd0,
        REG_KEY_COUNT   = 2'd1,
        REG_ENV_ENABLE  = 2'd2,
        REG_ALPHA_RATIO = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_START_RD,
        ST_START_CAP,
        ST_DIV,
        ST_FINISH
    } state_t;

    // One keyframe entry as held in the table memory
    typedef struct packed {
        logic [31:0] env;
        logic [39:0] prim;
        logic [15:0] key_time;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic [15:0] off_mag;
        logic [15:0] len_mag;
    } div_req_t;

endpackage

### rtl/keyframe_color_lerp.sv
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   tuser action, tdata load or evaluate fields
// m_       out        m_tvalid/m_tready   tuser env_valid, tdata interpolated colours
// cfg_     in         cfg_valid/cfg_ready register index and write data
//
// A load item is written to the key table when taken. An evaluate item steps through the
// step modulo loop length (one remainder bit per cycle), a read and a compare for each key
// walked in the table memory (1 to 15 keys), and the nine-lane divider. A step past the
// last key or on a zero-length segment skips the divider.
// Reset (aresetn low, synchronous) restores the configuration registers, the state and
// m_tvalid; the key table is not cleared. A waiting result holds the block in its last
// state until m_tready; configuration writes are always taken.
module keyframe_color_lerp import kfcl_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // key_index, key_time, prim_rgba, prim_lod, env_rgba, step
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // prim_rgba_out, prim_lod_out, env_rgba_out
    output logic         m_tuser,   // env_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    // Input fields
    logic [3:0]  in_key_index;
    logic [15:0] in_key_time;
    logic [31:0] in_prim_rgba;
    logic [7:0]  in_prim_lod;
    logic [31:0] in_env_rgba;
    logic [31:0] in_step;
    action_t     in_action;

    assign in_key_index = s_tdata[3:0];
    assign in_key_time  = s_tdata[19:4];
    assign in_prim_rgba = s_tdata[51:20];
    assign in_prim_lod  = s_tdata[59:52];
    assign in_env_rgba  = s_tdata[91:60];
    assign in_step      = s_tdata[123:92];
    assign in_action    = action_t'(s_tuser);

    // Configuration registers
    logic [15:0]      loop_length_reg;
    logic [CNT_W-1:0] key_count_reg;
    logic             env_enable_reg;
    logic [8:0]       alpha_ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_length_reg <= 16'd1;
            key_count_reg   <= CNT_W'(2);
            env_enable_reg  <= 1'b0;
            alpha_ratio_reg <= 9'd256;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOOP_LENGTH: loop_length_reg <= cfg_data;
                REG_KEY_COUNT:   key_count_reg   <= cfg_data[CNT_W-1:0];
                REG_ENV_ENABLE:  env_enable_reg  <= cfg_data[0];
                REG_ALPHA_RATIO: alpha_ratio_reg <= cfg_data[8:0];
            endcase
        end
    end

    // Clamped count and modulus
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(KEY_LIMIT);
    logic [CNT_W-1:0] cnt_clamp;
    logic [15:0]      modulus;

    assign cnt_clamp = (key_count_reg < CNT_W'(2)) ? CNT_W'(2) :
                       (key_count_reg > CNT_LIMIT) ? CNT_LIMIT : key_count_reg;
    assign modulus   = (loop_length_reg == 16'd0) ? 16'd1 : loop_length_reg;

    // Key table memory
    logic              ram_we;
    logic [KEY_AW-1:0] ram_addr;
    key_entry_t        ram_wdata;
    key_entry_t        ram_rdata;

    kfcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_LIMIT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ram_wdata = '{env: in_env_rgba, prim: {in_prim_rgba, in_prim_lod},
                         key_time: in_key_time};

    // Sequencer registers
    state_t               state_reg, state_next;
    logic [4:0]           mod_cnt_reg, mod_cnt_next;
    logic [31:0]          step_reg, step_next;
    logic [15:0]          frame_reg, frame_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     walk_idx_reg, walk_idx_next;
    key_entry_t           end_reg, end_next;
    logic [WORD_W-1:0]    start_reg, start_next;
    logic                 flat_reg, flat_next;
    logic [NUM_LANES-1:0] neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [71:0]          m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    // Datapath helpers
    logic [16:0]                 mod_trial;
    logic                        mod_fits;
    logic [WORD_W-1:0]           seg_start;
    logic [WORD_W-1:0]           seg_end;
    logic [16:0]                 seg_len;
    logic [16:0]                 seg_off;
    logic [NUM_LANES-1:0][8:0]   lane_delta;
    logic [NUM_LANES-1:0][7:0]   lane_mag;
    logic [NUM_LANES-1:0]        lane_neg;
    logic [WORD_W-1:0]           interp;
    logic [WORD_W-1:0]           result_word;
    logic [8:0]                  ratio;
    logic [16:0]                 alpha_prod;
    div_req_t                    div_req;
    logic                        div_done;
    logic [NUM_LANES-1:0][7:0]   div_quot;

    kfcl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .d_mag   (lane_mag),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Remainder step of the frame modulo
    assign mod_trial = {frame_reg, step_reg[31]};
    assign mod_fits  = (mod_trial >= {1'b0, modulus});

    // Segment geometry from the start entry now on the read port and the held end entry
    assign seg_start = {ram_rdata.env, ram_rdata.prim};
    assign seg_end   = {end_reg.env, end_reg.prim};
    assign seg_len   = {1'b0, end_reg.key_time} - {1'b0, ram_rdata.key_time};
    assign seg_off   = {1'b0, frame_reg} - {1'b0, ram_rdata.key_time};

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            lane_delta[k] = {1'b0, seg_end[8*k +: 8]} - {1'b0, seg_start[8*k +: 8]};
            lane_mag[k]   = lane_delta[k][8] ? 8'(-lane_delta[k]) : lane_delta[k][7:0];
            lane_neg[k]   = lane_delta[k][8] ^ seg_off[16] ^ seg_len[16];
        end
    end

    // Add signed quotients to the start bytes, wrapping per lane
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            interp[8*k +: 8] = start_reg[8*k +: 8]
                             + (neg_reg[k] ? 8'(-div_quot[k]) : div_quot[k]);
        end
    end

    assign result_word = flat_reg ? start_reg : interp;
    assign ratio       = (alpha_ratio_reg > 9'd256) ? 9'd256 : alpha_ratio_reg;
    assign alpha_prod  = result_word[15:8] * ratio;

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        mod_cnt_next  = mod_cnt_reg;
        step_next     = step_reg;
        frame_next    = frame_reg;
        cnt_next      = cnt_reg;
        walk_idx_next = walk_idx_reg;
        end_next      = end_reg;
        start_next    = start_reg;
        flat_next     = flat_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = walk_idx_reg[KEY_AW-1:0];
        div_req       = '{start: 1'b0,
                          off_mag: seg_off[16] ? 16'(-seg_off) : seg_off[15:0],
                          len_mag: seg_len[16] ? 16'(-seg_len) : seg_len[15:0]};

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_addr = in_key_index[KEY_AW-1:0];
                if (s_tvalid) begin
                    if (in_action == ACT_LOAD) begin
                        ram_we = ({1'b0, in_key_index} < CNT_LIMIT);
                    end else begin
                        step_next    = in_step;
                        frame_next   = '0;
                        mod_cnt_next = '0;
                        cnt_next     = cnt_clamp;
                        state_next   = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                frame_next   = mod_fits ? 16'(mod_trial - {1'b0, modulus})
                                        : mod_trial[15:0];
                step_next    = {step_reg[30:0], 1'b0};
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == 5'd31) begin
                    walk_idx_next = CNT_W'(1);
                    state_next    = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                end_next = ram_rdata;
                priority if (frame_reg < ram_rdata.key_time) begin
                    state_next = ST_START_RD;
                end else if (CNT_W'(walk_idx_reg + 1'b1) < cnt_reg) begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                    state_next    = ST_WALK_RD;
                end else begin
                    // Past the last key: hold its colours
                    start_next = {ram_rdata.env, ram_rdata.prim};
                    flat_next  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_START_RD: begin
                ram_addr   = KEY_AW'(walk_idx_reg - 1'b1);
                state_next = ST_START_CAP;
            end
            ST_START_CAP: begin
                start_next = seg_start;
                neg_next   = lane_neg;
                if (seg_len == 17'd0) begin
                    flat_next  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    flat_next     = 1'b0;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {env_enable_reg ? result_word[WORD_W-1:8*PRIM_LANES]
                                                   : 32'd0,
                                    result_word[7:0],
                                    result_word[39:16], alpha_prod[15:8]};
                    m_user_next  = env_enable_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mod_cnt_reg  <= mod_cnt_next;
        step_reg     <= step_next;
        frame_reg    <= frame_next;
        cnt_reg      <= cnt_next;
        walk_idx_reg <= walk_idx_next;
        end_reg      <= end_next;
        start_reg    <= start_next;
        flat_reg     <= flat_next;
        neg_reg      <= neg_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_RD) |-> (walk_idx_reg != '0 && walk_idx_reg < cnt_reg))
        else $error("key walk index outside the keys in use");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_eval_starts_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_MOD))
        else $error("evaluate item did not start the modulo");

    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid && !m_tready)
            |=> (state_reg == ST_FINISH && m_tvalid))
        else $error("result overwritten while the previous one waits");

endmodule

### rtl/kfcl_ram.sv
module kfcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write through the single port, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/kfcl_div.sv
module kfcl_div import kfcl_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  div_req_t                      req,
    input  logic [NUM_LANES-1:0][7:0]     d_mag,
    output logic                          done,
    output logic [NUM_LANES-1:0][7:0]     quot
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [STEP_W-1:0]                 cnt_reg, cnt_next;
    logic [15:0]                       divisor_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0]  dvd_reg, dvd_next;
    logic [NUM_LANES-1:0][15:0]        rem_reg, rem_next;
    logic [NUM_LANES-1:0][16:0]        trial;
    logic [NUM_LANES-1:0]              fits;

    // Control: the products are loaded at start, then one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Restoring division step in every lane against the shared divisor
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k] = {rem_reg[k], dvd_reg[k][PROD_W-1]};
            fits[k]  = (trial[k] >= {1'b0, divisor_reg});
            if (req.start) begin
                dvd_next[k] = PROD_W'(d_mag[k] * req.off_mag);
                rem_next[k] = '0;
            end else if (busy_reg) begin
                rem_next[k] = fits[k] ? 16'(trial[k] - {1'b0, divisor_reg})
                                      : trial[k][15:0];
                dvd_next[k] = {dvd_reg[k][PROD_W-2:0], fits[k]};
            end else begin
                rem_next[k] = rem_reg[k];
                dvd_next[k] = dvd_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            divisor_reg <= req.len_mag;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    // Quotient has shifted fully into the dividend register when done
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            quot[k] = dvd_reg[k][7:0];
        end
    end

    assign done = done_reg;

endmodule

### verif/keyframe_color_lerp_tb.sv
module keyframe_color_lerp_tb;
    import kfcl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 120;
    localparam int HOLD_CYCLES = 1500;
    localparam int NUM_PHASES  = 10;
    localparam int EVALS_PER_PHASE = 77;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EVAL,
        ROW_CFG
    } row_kind_t;

    // One interpolated result as it leaves the block
    typedef struct packed {
        logic [31:0] prim_rgba;
        logic [7:0]  prim_lod;
        logic [31:0] env_rgba;
        logic        env_valid;
    } colour_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  idx;
        logic [15:0] kt;
        logic [31:0] prgba;
        logic [7:0]  lod;
        logic [31:0] ergba;
        logic [31:0] stp;
        cfg_reg_t    reg_sel;
        logic [15:0] reg_val;
        bit          typed;
        colour_t     want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // key_index, key_time, prim_rgba, prim_lod, env_rgba, step
    logic         s_tuser;   // action
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // prim_rgba_out, prim_lod_out, env_rgba_out
    logic         m_tuser;   // env_valid
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // Shadow keyframe table and registers
    logic [15:0] key_time_tab [16];
    logic [39:0] prim_tab     [16];
    logic [31:0] env_tab      [16];
    logic [15:0] loop_len_r;
    logic [4:0]  key_cnt_r;
    logic        env_en_r;
    logic [8:0]  alpha_ratio_r;

    colour_t colour_q [$];
    row_t    dir_rows [$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    int      send_pct = 11;
    int      recv_pct = 48;
    bit      hold_req = 1'b0;

    keyframe_color_lerp u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One byte lane: start plus truncated signed quotient, wrapped to 8 bits
    function automatic logic [7:0] lerp_lane(input logic [7:0] a, input logic [7:0] b,
                                             input longint off, input longint len);
        longint d;
        longint r;
        d = longint'(b) - longint'(a);
        r = longint'(a) + (d * off) / len;
        return r[7:0];
    endfunction

    function automatic colour_t predict_colour(input logic [31:0] stp);
        int unsigned cnt;
        int unsigned len_eff;
        int unsigned frame;
        int unsigned ratio;
        int unsigned alpha;
        int          i;
        longint      seg_start;
        longint      seg_len;
        longint      off;
        logic [39:0] p;
        logic [31:0] e;
        colour_t     r;
        cnt = key_cnt_r;
        if (cnt < 2) cnt = 2;
        if (cnt > KEY_LIMIT) cnt = KEY_LIMIT;
        len_eff = (loop_len_r == 0) ? 1 : loop_len_r;
        frame = stp % len_eff;
        i = 1;
        while (i < cnt && frame >= key_time_tab[i]) i++;
        if (i >= cnt) begin
            p = prim_tab[cnt-1];
            e = env_tab[cnt-1];
        end else begin
            seg_start = longint'(key_time_tab[i-1]);
            seg_len   = longint'(key_time_tab[i]) - seg_start;
            off       = longint'(frame) - seg_start;
            p = prim_tab[i-1];
            e = env_tab[i-1];
            // Zero-length segment keeps the start colours
            if (seg_len != 0) begin
                for (int k = 0; k < PRIM_LANES; k++)
                    p[8*k +: 8] = lerp_lane(prim_tab[i-1][8*k +: 8], prim_tab[i][8*k +: 8],
                                            off, seg_len);
                for (int k = 0; k < 4; k++)
                    e[8*k +: 8] = lerp_lane(env_tab[i-1][8*k +: 8], env_tab[i][8*k +: 8],
                                            off, seg_len);
            end
        end
        ratio = (alpha_ratio_r > 256) ? 256 : alpha_ratio_r;
        alpha = (int'(p[15:8]) * ratio) >> 8;
        r.prim_rgba = {p[39:16], alpha[7:0]};
        r.prim_lod  = p[7:0];
        r.env_rgba  = env_en_r ? e : 32'h0;
        r.env_valid = env_en_r;
        return r;
    endfunction

    function automatic row_t load_row(input logic [3:0] idx, input logic [15:0] kt,
                                      input logic [31:0] prgba, input logic [7:0] lod,
                                      input logic [31:0] ergba);
        row_t r;
        r = '{kind: ROW_LOAD, reg_sel: REG_LOOP_LENGTH, default: '0};
        r.idx = idx; r.kt = kt; r.prgba = prgba; r.lod = lod; r.ergba = ergba;
        return r;
    endfunction

    function automatic row_t eval_row(input logic [31:0] stp, input bit typed,
                                      input colour_t want);
        row_t r;
        r = '{kind: ROW_EVAL, reg_sel: REG_LOOP_LENGTH, default: '0};
        r.stp = stp; r.typed = typed; r.want = want;
        return r;
    endfunction

    function automatic row_t cfg_row(input cfg_reg_t sel, input logic [15:0] val);
        row_t r;
        r = '{kind: ROW_CFG, reg_sel: sel, default: '0};
        r.reg_val = val;
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then update the shadow state
    task automatic send_item(input action_t act, input logic [3:0] idx, input logic [15:0] kt,
                             input logic [31:0] prgba, input logic [7:0] lod,
                             input logic [31:0] ergba, input logic [31:0] stp,
                             input bit typed, input colour_t want);
        while ($urandom_range(99) < send_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, stp, ergba, lod, prgba, kt, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == ACT_LOAD) begin
            key_time_tab[idx] = kt;
            prim_tab[idx]     = {prgba, lod};
            env_tab[idx]      = ergba;
        end else begin
            colour_q.push_back(typed ? want : predict_colour(stp));
        end
    endtask

    // Hold the sender until every result is out and the block has settled
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (colour_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (sel)
            REG_LOOP_LENGTH: loop_len_r    = val;
            REG_KEY_COUNT:   key_cnt_r     = val[4:0];
            REG_ENV_ENABLE:  env_en_r      = val[0];
            REG_ALPHA_RATIO: alpha_ratio_r = val[8:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One phase: set registers (fixed corners first, then random), fill the table, then evaluate with some noise
    task automatic run_phase(input int ph);
        logic [15:0] loop_v;
        logic [4:0]  kc_v;
        logic        env_v;
        logic [8:0]  alpha_v;
        int unsigned len_eff;
        int unsigned inc_max;
        int unsigned t;
        logic [15:0] kt;
        logic [31:0] stp;
        case (ph)
            0: begin loop_v = 16'hFFFF; kc_v = 5'd16; env_v = 1'b1; alpha_v = 9'd256; end
            1: begin loop_v = 16'd1;    kc_v = 5'd2;  env_v = 1'b0; alpha_v = 9'd0;   end
            2: begin loop_v = 16'd0;    kc_v = 5'd31; env_v = 1'b1; alpha_v = 9'd511; end
            3: begin loop_v = 16'd1000; kc_v = 5'd17; env_v = 1'b1; alpha_v = 9'd128; end
            4: begin loop_v = 16'd300;  kc_v = 5'd0;  env_v = 1'b0; alpha_v = 9'd257; end
            default: begin
                loop_v  = 16'($urandom_range(65535, 2));
                kc_v    = 5'($urandom_range(31));
                env_v   = 1'($urandom_range(1));
                alpha_v = 9'($urandom_range(511));
            end
        endcase
        if (ph < 4) begin
            send_pct = 11; recv_pct = 48;
        end else if (ph < 7) begin
            send_pct = 48; recv_pct = 11;
        end else begin
            send_pct = 0;  recv_pct = 0;
        end
        drain();
        write_reg(REG_LOOP_LENGTH, loop_v);
        write_reg(REG_KEY_COUNT, {11'b0, kc_v});
        write_reg(REG_ENV_ENABLE, {15'b0, env_v});
        write_reg(REG_ALPHA_RATIO, {7'b0, alpha_v});
        cfg_close();

        // Mostly ascending key times across the loop, with repeats and strays
        len_eff = (loop_v == 0) ? 1 : loop_v;
        inc_max = len_eff / 8 + 1;
        t = $urandom_range(len_eff / 16);
        for (int k = 0; k < 16; k++) begin
            if (k > 0)
                t += ($urandom_range(9) == 0) ? 0 : $urandom_range(inc_max, 1);
            kt = (t > 65535) ? 16'hFFFF : 16'(t);
            if ($urandom_range(7) == 0) kt = 16'($urandom_range(65535));
            send_item(ACT_LOAD, 4'(k), kt, $urandom, 8'($urandom), $urandom, $urandom,
                      1'b0, '0);
        end

        for (int n = 0; n < EVALS_PER_PHASE; n++) begin
            if (ph == 2 && n == 20) hold_req = 1'b1;
            if (ph == 5 && n == 30) drain();
            if ($urandom_range(11) == 0)
                send_item(ACT_LOAD, 4'($urandom_range(15)), 16'($urandom), $urandom,
                          8'($urandom), $urandom, $urandom, 1'b0, '0);
            if ($urandom_range(9) < 3)
                stp = key_time_tab[$urandom_range(15)] + len_eff * $urandom_range(65535);
            else
                stp = $urandom;
            send_item(ACT_EVAL, 4'($urandom), 16'($urandom), $urandom, 8'($urandom),
                      $urandom, stp, 1'b0, '0);
        end
    endtask

    // Receiver: random back-pressure, or a long hold when asked
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end else begin
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Compare each result with the oldest expected colour
    always @(posedge aclk) begin
        colour_t got;
        colour_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[39:32], m_tdata[71:40], m_tuser};
            if (colour_q.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, got);
                fail_cnt++;
            end else begin
                exp_c = colour_q.pop_front();
                if (got.prim_rgba !== exp_c.prim_rgba) begin
                    $display("%0t: prim_rgba expected %h actual %h", $time,
                             exp_c.prim_rgba, got.prim_rgba);
                    fail_cnt++;
                end
                if (got.prim_lod !== exp_c.prim_lod) begin
                    $display("%0t: prim_lod expected %h actual %h", $time,
                             exp_c.prim_lod, got.prim_lod);
                    fail_cnt++;
                end
                if (got.env_rgba !== exp_c.env_rgba) begin
                    $display("%0t: env_rgba expected %h actual %h", $time,
                             exp_c.env_rgba, got.env_rgba);
                    fail_cnt++;
                end
                if (got.env_valid !== exp_c.env_valid) begin
                    $display("%0t: env_valid expected %b actual %b", $time,
                             exp_c.env_valid, got.env_valid);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("keyframe_color_lerp verification failed");
            $finish;
        end
    end

    initial begin
        bit in_cfg;
        row_t r;
        in_cfg = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        loop_len_r    = 16'd1;
        key_cnt_r     = 5'd2;
        env_en_r      = 1'b0;
        alpha_ratio_r = 9'd256;

        // Directed table; typed results where they follow at a glance
        dir_rows.push_back(load_row(4'd0, 16'd0,  32'hFF000080, 8'h00, 32'h00000000));
        dir_rows.push_back(load_row(4'd1, 16'd20, 32'h00FF00FF, 8'hFF, 32'hFFFFFFFF));
        dir_rows.push_back(load_row(4'd2, 16'd20, 32'h12345678, 8'h9A, 32'h89ABCDEF));
        dir_rows.push_back(load_row(4'd3, 16'd5,  32'hFFFFFFFF, 8'h40, 32'h01020304));
        // reset settings give the first key's colours
        dir_rows.push_back(eval_row(32'd0, 1'b1, {32'hFF000080, 8'h00, 32'h0, 1'b0}));
        // zero loop length acts as one
        dir_rows.push_back(cfg_row(REG_LOOP_LENGTH, 16'd0));
        dir_rows.push_back(eval_row(32'hFFFFFFFF, 1'b1, {32'hFF000080, 8'h00, 32'h0, 1'b0}));
        dir_rows.push_back(cfg_row(REG_LOOP_LENGTH, 16'hFFFF));
        dir_rows.push_back(cfg_row(REG_ALPHA_RATIO, 16'd0));
        dir_rows.push_back(cfg_row(REG_ENV_ENABLE, 16'd1));
        dir_rows.push_back(cfg_row(REG_KEY_COUNT, 16'd4));
        dir_rows.push_back(eval_row(32'd15, 1'b0, '0));
        // past the last key, then a wrapped step at the first key; alpha scaled to zero
        dir_rows.push_back(eval_row(32'd20, 1'b1, {32'hFFFFFF00, 8'h40, 32'h01020304, 1'b1}));
        dir_rows.push_back(eval_row(32'd65535, 1'b1, {32'hFF000000, 8'h00, 32'h0, 1'b1}));
        // ratio above one saturates
        dir_rows.push_back(cfg_row(REG_ALPHA_RATIO, 16'd511));
        dir_rows.push_back(cfg_row(REG_KEY_COUNT, 16'd3));
        dir_rows.push_back(eval_row(32'd20, 1'b1, {32'h12345678, 8'h9A, 32'h89ABCDEF, 1'b1}));
        // count below two acts as two
        dir_rows.push_back(cfg_row(REG_ALPHA_RATIO, 16'd257));
        dir_rows.push_back(cfg_row(REG_KEY_COUNT, 16'd0));
        dir_rows.push_back(eval_row(32'd70000, 1'b1, {32'h00FF00FF, 8'hFF, 32'hFFFFFFFF, 1'b1}));
        dir_rows.push_back(cfg_row(REG_KEY_COUNT, 16'd1));
        dir_rows.push_back(cfg_row(REG_ALPHA_RATIO, 16'd128));
        dir_rows.push_back(eval_row(32'd10, 1'b0, '0));
        // zero-length first segment
        dir_rows.push_back(load_row(4'd0, 16'd20, 32'hAABBCCDD, 8'h11, 32'h55667788));
        dir_rows.push_back(eval_row(32'd7, 1'b1, {32'hAABBCC6E, 8'h11, 32'h55667788, 1'b1}));
        // frame before first key and keys out of order
        dir_rows.push_back(load_row(4'd0, 16'd30, 32'hAABBCCDD, 8'h11, 32'h55667788));
        dir_rows.push_back(eval_row(32'd5, 1'b0, '0));
        dir_rows.push_back(eval_row(32'd25, 1'b0, '0));
        dir_rows.push_back(cfg_row(REG_ENV_ENABLE, 16'd0));
        dir_rows.push_back(cfg_row(REG_ALPHA_RATIO, 16'd256));
        dir_rows.push_back(cfg_row(REG_KEY_COUNT, 16'd4));
        dir_rows.push_back(cfg_row(REG_LOOP_LENGTH, 16'd50));
        dir_rows.push_back(eval_row(32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 8'h40, 32'h0, 1'b0}));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            if (r.kind == ROW_CFG) begin
                if (!in_cfg) drain();
                in_cfg = 1'b1;
                write_reg(r.reg_sel, r.reg_val);
            end else begin
                if (in_cfg) cfg_close();
                in_cfg = 1'b0;
                send_item((r.kind == ROW_LOAD) ? ACT_LOAD : ACT_EVAL, r.idx, r.kt, r.prgba,
                          r.lod, r.ergba, r.stp, r.typed, r.want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

        drain();
        if (fail_cnt == 0)
            $display("keyframe_color_lerp verification clean");
        else
            $display("keyframe_color_lerp verification failed");
        $finish;
    end

endmodule

### files.f
rtl/kfcl_pkg.sv
rtl/kfcl_ram.sv
rtl/kfcl_div.sv
rtl/keyframe_color_lerp.sv
verif/keyframe_color_lerp_tb.sv
